/* sv/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is low.
`define TASP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tasp check failed");

// Clocked check that also runs through reset.
`define TASP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tasp check failed");

`endif

/* sv/tasp_pkg.sv */
`default_nettype none
package tasp_pkg;

    localparam int ANGLE_W   = 24;
    localparam int TIME_W    = 16;
    localparam int TIME_FRAC = 16;

    // rate * dt, then the whole-unit part of it
    localparam int PROD_W = ANGLE_W + TIME_W + 1;
    localparam int DISP_W = PROD_W - TIME_FRAC;
    // position sum before saturation, and its offset from the low limit
    localparam int POS_W  = ((ANGLE_W > DISP_W) ? ANGLE_W : DISP_W) + 1;
    localparam int DIFF_W = POS_W + 1;
    localparam int SAT_W  = DIFF_W + 1;

    // |width - 2*pi| < 0.01 rad in 2^-16 rad units
    localparam int CONT_MIN = 411120;
    localparam int CONT_MAX = 412430;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic [TIME_W-1:0]         t_time;
    typedef logic [1:0]                t_kind;

    localparam logic  CMD_TICK = 1'b0;
    localparam logic  CMD_SET  = 1'b1;
    localparam t_kind KIND_ABS  = 2'd0;
    localparam t_kind KIND_VEL  = 2'd1;
    localparam t_kind KIND_NONE = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] dividend;
        logic [DIFF_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIFF_W-1:0] rem;
    } t_div_rsp;

    function automatic t_angle sat_angle(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] amax;
        logic signed [SAT_W-1:0] amin;
        amax = {{(SAT_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
        amin = ~amax;
        if (v > amax) return amax[ANGLE_W-1:0];
        if (v < amin) return amin[ANGLE_W-1:0];
        return v[ANGLE_W-1:0];
    endfunction

    function automatic t_angle neg_sat(input t_angle r);
        if (r == {1'b1, {(ANGLE_W-1){1'b0}}}) return {1'b0, {(ANGLE_W-1){1'b1}}};
        return -r;
    endfunction

    function automatic logic is_cont(input t_angle lo, input t_angle hi);
        logic signed [ANGLE_W:0] w;
        w = (ANGLE_W+1)'(hi) - (ANGLE_W+1)'(lo);
        return (w >= CONT_MIN) && (w <= CONT_MAX);
    endfunction

endpackage
`default_nettype wire

/* sv/tasp_in_if.sv */
`default_nettype none
interface tasp_in_if import tasp_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   command;
    t_time  elapsed;
    t_kind  pitch_kind;
    t_kind  yaw_kind;
    t_angle pitch_angle;
    t_angle yaw_angle;
    t_angle pitch_speed;
    t_angle yaw_speed;
    t_angle pitch_low_limit;
    t_angle pitch_high_limit;
    t_angle yaw_low_limit;
    t_angle yaw_high_limit;

    modport source (
        output valid, command, elapsed, pitch_kind, yaw_kind, pitch_angle,
               yaw_angle, pitch_speed, yaw_speed, pitch_low_limit,
               pitch_high_limit, yaw_low_limit, yaw_high_limit,
        input  ready
    );
    modport sink (
        input  valid, command, elapsed, pitch_kind, yaw_kind, pitch_angle,
               yaw_angle, pitch_speed, yaw_speed, pitch_low_limit,
               pitch_high_limit, yaw_low_limit, yaw_high_limit,
        output ready
    );
endinterface
`default_nettype wire

/* sv/tasp_out_if.sv */
`default_nettype none
interface tasp_out_if import tasp_pkg::*; ();
    logic   valid;
    logic   ready;
    t_angle pitch_position;
    t_angle yaw_position;

    modport source (output valid, pitch_position, yaw_position, input ready);
    modport sink   (input valid, pitch_position, yaw_position, output ready);
endinterface
`default_nettype wire

/* sv/tasp_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module tasp_div import tasp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    localparam int CNT_W = $clog2(DIFF_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIFF_W-1:0] r_dvd;
    logic [DIFF_W-1:0] r_dvs;
    logic [DIFF_W-1:0] r_rem;

    logic [DIFF_W:0]   shifted;
    logic [DIFF_W:0]   trial;
    logic [DIFF_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DIFF_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        n_rem   = trial[DIFF_W] ? shifted[DIFF_W-1:0] : trial[DIFF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIFF_W - 1);
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DIFF_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

/* sv/two_axis_scan_position_generator.sv */
// Set word: taken and applied in its accept cycle, the block stays ready.
// Armed tick word: ready drops while each axis is stepped: a position-mode axis is skipped,
// a velocity-mode axis is multiplied, added and checked, and also waits on the shared
// remainder divider when it wraps; then the output register is loaded, later while the last word waits.
// The first tick after reset only arms the block. Reset (synchronous, active low)
// zeroes positions, rates, limits, modes, the previous set word and the arm flag.
`default_nettype none
module two_axis_scan_position_generator import tasp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tasp_in_if.sink   i_in,
    tasp_out_if.source o_out
);
    // One-hot sequencer. Axis 0 is pitch, axis 1 is yaw; both run through
    // the same multiplier, adder and divider, one after the other.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEL  = 6'b000010,   // skip position-mode axis, else multiply
        ST_ADD  = 6'b000100,   // position + displacement
        ST_CHK  = 6'b001000,   // limit test or divider launch
        ST_DIV  = 6'b010000,   // wait for wrap remainder
        ST_PUSH = 6'b100000    // load output register
    } t_state;

    t_state r_state;
    logic   r_axis;
    logic   r_armed;

    // axis state
    t_angle     r_now  [2];
    t_angle     r_rate [2];
    t_angle     r_lo   [2];
    t_angle     r_hi   [2];
    logic [1:0] r_vmode;
    logic [1:0] r_wraps;

    // last applied set word, for repeat detection
    logic [3:0] r_prev_types;
    t_angle     r_prev [8];

    // datapath
    t_time                   r_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [POS_W-1:0]  r_pos;
    logic                    r_neg;

    // output register
    logic   r_out_valid;
    t_angle r_out_pitch;
    t_angle r_out_yaw;

    t_div_req div_req;
    t_div_rsp div_rsp;

    tasp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    logic                     in_fire;
    logic                     same_c;
    t_angle                   cur_now;
    t_angle                   cur_rate;
    t_angle                   cur_lo;
    t_angle                   cur_hi;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [POS_W-1:0]  pos_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic signed [ANGLE_W:0]  span_c;
    logic [DIFF_W-1:0]        mag_c;
    logic                     wrap_div;
    logic                     gt_hi;
    logic                     lt_lo;
    t_angle                   pos_sat;
    logic signed [SAT_W-1:0]  fix_c;

    assign in_fire = i_in.valid && i_in.ready;

    // repeated set words are dropped
    assign same_c = ({i_in.yaw_kind, i_in.pitch_kind} == r_prev_types)
                 && (i_in.pitch_angle      == r_prev[0])
                 && (i_in.yaw_angle        == r_prev[1])
                 && (i_in.pitch_speed      == r_prev[2])
                 && (i_in.yaw_speed        == r_prev[3])
                 && (i_in.pitch_low_limit  == r_prev[4])
                 && (i_in.pitch_high_limit == r_prev[5])
                 && (i_in.yaw_low_limit    == r_prev[6])
                 && (i_in.yaw_high_limit   == r_prev[7]);

    assign cur_now  = r_now[r_axis];
    assign cur_rate = r_rate[r_axis];
    assign cur_lo   = r_lo[r_axis];
    assign cur_hi   = r_hi[r_axis];

    // displacement = floor(rate * dt / 2^16): drop the fraction bits
    assign prod_c = PROD_W'(cur_rate) * PROD_W'($signed({1'b0, r_dt}));
    assign pos_c  = POS_W'(cur_now) + POS_W'($signed(r_prod[PROD_W-1:TIME_FRAC]));

    assign diff_c   = DIFF_W'(r_pos) - DIFF_W'(cur_lo);
    assign span_c   = (ANGLE_W+1)'(cur_hi) - (ANGLE_W+1)'(cur_lo);
    assign mag_c    = diff_c[DIFF_W-1] ? DIFF_W'(-diff_c) : DIFF_W'(diff_c);
    assign wrap_div = r_wraps[r_axis] && (span_c > 0);
    assign gt_hi    = r_pos > POS_W'(cur_hi);
    assign lt_lo    = r_pos < POS_W'(cur_lo);
    assign pos_sat  = sat_angle(SAT_W'(r_pos));

    // Truncated remainder has the sign of the offset; a negative nonzero
    // one is folded up by the width, landing at hi - |rem|.
    assign fix_c = (r_neg && (div_rsp.rem != '0))
                 ? SAT_W'(cur_hi) - $signed({1'b0, div_rsp.rem})
                 : SAT_W'(cur_lo) + $signed({1'b0, div_rsp.rem});

    assign div_req.start    = (r_state == ST_CHK) && wrap_div;
    assign div_req.dividend = mag_c;
    assign div_req.divisor  = DIFF_W'(span_c[ANGLE_W-1:0]);

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.pitch_position = r_out_pitch;
    assign o_out.yaw_position   = r_out_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_axis       <= 1'b0;
            r_armed      <= 1'b0;
            r_vmode      <= '0;
            r_wraps      <= '0;
            r_prev_types <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_now[i]  <= '0;
                r_rate[i] <= '0;
                r_lo[i]   <= '0;
                r_hi[i]   <= '0;
            end
            for (int i = 0; i < 8; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            // ST_PUSH owns the valid flag while it runs
            if (o_out.ready && (r_state != ST_PUSH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in.command == CMD_SET) begin
                            if (!same_c) begin
                                r_prev_types <= {i_in.yaw_kind, i_in.pitch_kind};
                                r_prev[0] <= i_in.pitch_angle;
                                r_prev[1] <= i_in.yaw_angle;
                                r_prev[2] <= i_in.pitch_speed;
                                r_prev[3] <= i_in.yaw_speed;
                                r_prev[4] <= i_in.pitch_low_limit;
                                r_prev[5] <= i_in.pitch_high_limit;
                                r_prev[6] <= i_in.yaw_low_limit;
                                r_prev[7] <= i_in.yaw_high_limit;
                                // pitch
                                if (i_in.pitch_kind == KIND_ABS) begin
                                    r_now[0]   <= i_in.pitch_angle;
                                    r_vmode[0] <= 1'b0;
                                end else if (i_in.pitch_kind == KIND_VEL) begin
                                    r_vmode[0] <= 1'b1;
                                    r_rate[0]  <= i_in.pitch_speed;
                                    r_lo[0]    <= i_in.pitch_low_limit;
                                    r_hi[0]    <= i_in.pitch_high_limit;
                                    r_wraps[0] <= is_cont(i_in.pitch_low_limit,
                                                          i_in.pitch_high_limit);
                                end
                                // yaw
                                if (i_in.yaw_kind == KIND_ABS) begin
                                    r_now[1]   <= i_in.yaw_angle;
                                    r_vmode[1] <= 1'b0;
                                end else if (i_in.yaw_kind == KIND_VEL) begin
                                    r_vmode[1] <= 1'b1;
                                    r_rate[1]  <= i_in.yaw_speed;
                                    r_lo[1]    <= i_in.yaw_low_limit;
                                    r_hi[1]    <= i_in.yaw_high_limit;
                                    r_wraps[1] <= is_cont(i_in.yaw_low_limit,
                                                          i_in.yaw_high_limit);
                                end
                            end
                        end else if (!r_armed) begin
                            r_armed <= 1'b1;
                        end else begin
                            r_dt    <= i_in.elapsed;
                            r_axis  <= 1'b0;
                            r_state <= ST_SEL;
                        end
                    end
                end
                ST_SEL: begin
                    if (r_vmode[r_axis]) begin
                        r_prod  <= prod_c;
                        r_state <= ST_ADD;
                    end else if (!r_axis) begin
                        r_axis <= 1'b1;
                    end else begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_ADD: begin
                    r_pos   <= pos_c;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_neg <= diff_c[DIFF_W-1];
                    if (wrap_div) begin
                        r_state <= ST_DIV;
                    end else begin
                        if (r_wraps[r_axis]) begin
                            r_now[r_axis] <= pos_sat;
                        end else if (gt_hi) begin
                            // reflect: stop at the limit, reverse
                            r_now[r_axis]  <= cur_hi;
                            r_rate[r_axis] <= neg_sat(cur_rate);
                        end else if (lt_lo) begin
                            r_now[r_axis]  <= cur_lo;
                            r_rate[r_axis] <= neg_sat(cur_rate);
                        end else begin
                            r_now[r_axis] <= pos_sat;
                        end
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= ST_SEL;
                        end else begin
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_now[r_axis] <= sat_angle(fix_c);
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= ST_SEL;
                        end else begin
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_PUSH: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_pitch <= r_now[0];
                        r_out_yaw   <= r_now[1];
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* sv/tasp_chk.sv */
`default_nettype none
`include "assert_macros.svh"
module tasp_chk import tasp_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   i_in_valid,
    input wire logic   i_in_ready,
    input wire logic   i_in_command,
    input wire logic   i_out_valid,
    input wire logic   i_out_ready,
    input wire t_angle i_out_pitch,
    input wire t_angle i_out_yaw
);
    // result word held until taken
    `TASP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `TASP_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_pitch) && $stable(i_out_yaw))

    // ready right after reset
    `TASP_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> i_in_ready)

    // set words finish in the accept cycle
    `TASP_ASSERT(a_set_quick, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_command == CMD_SET) |=> i_in_ready)

    // only an accepted tick makes the block busy
    `TASP_ASSERT(a_busy_src, i_clk, i_rst_n, $fell(i_in_ready) |-> $past(i_in_valid && (i_in_command == CMD_TICK)))
endmodule

bind two_axis_scan_position_generator tasp_chk u_tasp_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_pitch  (o_out.pitch_position),
    .i_out_yaw    (o_out.yaw_position)
);
`default_nettype wire
